// ----- hdl/yrd_pkg.sv -----
// ----------------------------------------------------------------------------
// yrd_pkg
// Shared widths, constants and types of the detector record decoder.
// ----------------------------------------------------------------------------
package yrd_pkg;

   localparam int ELEM_W  = 8;
   localparam int REC_W   = 15;
   localparam int CLS_W   = 7;
   localparam int SCORE_W = 16;
   localparam int COORD_W = 17;
   localparam int SCALE_W = 24;
   localparam int INV_W   = 12;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 3;

   // dequantized value: (q - zp) * scale fits 33 bits signed
   localparam int DQ_W = 33;

   // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for every 32-bit v
   localparam logic [31:0] RECIP_100   = 32'd2748779070;
   localparam int          RECIP_SHIFT = 38;
   localparam int          Q_FRAC      = 16;
   localparam logic [COORD_W-1:0] COORD_ONE = 17'd65536;

   // position of the last leading non-class element (the score) in a record
   localparam logic [CLS_W-1:0] HEAD_LAST = 7'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SIZE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_COUNT = 3'd6;

   typedef struct packed {
      logic signed [ELEM_W-1:0] quant_offset;
      logic [SCALE_W-1:0]       scale_q16;
      logic                     pixel_mode;
      logic [SCORE_W-1:0]       score_threshold;
      logic [CLS_W-1:0]         class_count;
      logic [INV_W-1:0]         inv_size;
      logic [REC_W-1:0]         record_count;
   } cfg_type;

   typedef struct packed {
      logic [REC_W-1:0]               record_index;
      logic [CLS_W-1:0]               class_index;
      logic signed [ELEM_W-1:0]       score;
      logic signed [3:0][ELEM_W-1:0]  coords;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hdl/yrd_req_if.sv -----
// ----------------------------------------------------------------------------
// yrd_req_if
// Element stream channel: one raw tensor byte per beat.
// ----------------------------------------------------------------------------
interface yrd_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [yrd_pkg::ELEM_W-1:0] element;
   logic                              frame_start;

   modport source (output valid, output element, output frame_start, input ready);
   modport sink   (input valid, input element, input frame_start, output ready);
endinterface

// ----- hdl/yrd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// yrd_rsp_if
// Box channel: one decoded detection per beat.
// ----------------------------------------------------------------------------
interface yrd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [yrd_pkg::REC_W-1:0]    record_index;
   logic [yrd_pkg::CLS_W-1:0]    class_index;
   logic [yrd_pkg::SCORE_W-1:0]  score;
   logic [yrd_pkg::COORD_W-1:0]  box_x;
   logic [yrd_pkg::COORD_W-1:0]  box_y;
   logic [yrd_pkg::COORD_W-1:0]  box_w;
   logic [yrd_pkg::COORD_W-1:0]  box_h;

   modport source (output valid, output record_index, output class_index, output score,
                   output box_x, output box_y, output box_w, output box_h, input ready);
   modport sink   (input valid, input record_index, input class_index, input score,
                   input box_x, input box_y, input box_w, input box_h, output ready);
endinterface

// ----- hdl/yrd_front.sv -----
// ----------------------------------------------------------------------------
// yrd_front
// Takes one element per beat, captures box bytes, tracks the class argmax and
// pushes a record job at the end of each record.
// ----------------------------------------------------------------------------
module yrd_front #(
   parameter int unsigned MAX_CLASSES = 80,
   parameter int unsigned MAX_RECORDS = 32768
) (
   input  logic                     clock,
   input  logic                     reset,
   input  yrd_pkg::cfg_type         cfg,
   yrd_req_if.sink                  req,
   input  yrd_pkg::queue_status_type q_status,
   output logic                     push,
   output yrd_pkg::job_type         job
);

   localparam logic [yrd_pkg::CLS_W-1:0] MAX_CLS_V = yrd_pkg::CLS_W'(MAX_CLASSES);
   localparam logic [yrd_pkg::REC_W:0]   MAX_REC_V = (yrd_pkg::REC_W+1)'(MAX_RECORDS);

   logic [yrd_pkg::CLS_W-1:0]          pos_ff, pos_in;
   logic signed [yrd_pkg::ELEM_W-1:0]  best_val_ff, best_val_in;
   logic [yrd_pkg::CLS_W-1:0]          best_cls_ff, best_cls_in;
   logic [yrd_pkg::REC_W-1:0]          rec_ff, rec_in;
   logic signed [3:0][yrd_pkg::ELEM_W-1:0] coords_ff;
   logic signed [yrd_pkg::ELEM_W-1:0]  score_ff;

   logic                               accept;
   logic [yrd_pkg::CLS_W-1:0]          pos_cur;
   logic signed [yrd_pkg::ELEM_W-1:0]  best_val_cur, best_val_nxt;
   logic [yrd_pkg::CLS_W-1:0]          best_cls_cur, best_cls_nxt;
   logic [yrd_pkg::REC_W-1:0]          rec_cur;
   logic [yrd_pkg::CLS_W-1:0]          classes;
   logic [yrd_pkg::CLS_W-1:0]          last_pos;
   logic [yrd_pkg::REC_W:0]            records;
   logic [yrd_pkg::REC_W:0]            rec_inc;
   logic                               rec_end;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // frame start restarts the record on this very beat
      pos_cur      = req.frame_start ? '0 : pos_ff;
      best_val_cur = req.frame_start ? -8'sd128 : best_val_ff;
      best_cls_cur = req.frame_start ? '0 : best_cls_ff;
      rec_cur      = req.frame_start ? '0 : rec_ff;

      if (cfg.class_count == '0) begin
         classes = 7'd1;
      end else if (32'(cfg.class_count) > MAX_CLASSES) begin
         classes = MAX_CLS_V;
      end else begin
         classes = cfg.class_count;
      end
      last_pos = yrd_pkg::HEAD_LAST + classes;

      if (cfg.record_count == '0) begin
         records = 16'd1;
      end else if (32'(cfg.record_count) > MAX_RECORDS) begin
         records = MAX_REC_V;
      end else begin
         records = {1'b0, cfg.record_count};
      end
      rec_inc = {1'b0, rec_cur} + 16'd1;

      best_val_nxt = best_val_cur;
      best_cls_nxt = best_cls_cur;
      if (pos_cur > yrd_pkg::HEAD_LAST && req.element > best_val_cur) begin
         best_val_nxt = req.element;
         best_cls_nxt = pos_cur - 7'd5;
      end

      rec_end = pos_cur >= last_pos;

      if (rec_end) begin
         pos_in      = '0;
         best_val_in = -8'sd128;
         best_cls_in = '0;
         rec_in      = (rec_inc >= records) ? '0 : rec_inc[yrd_pkg::REC_W-1:0];
      end else begin
         pos_in      = pos_cur + 7'd1;
         best_val_in = best_val_nxt;
         best_cls_in = best_cls_nxt;
         rec_in      = rec_cur;
      end
   end

   assign push             = accept && rec_end;
   assign job.record_index = rec_cur;
   assign job.class_index  = best_cls_nxt;
   assign job.score        = score_ff;
   assign job.coords       = coords_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         best_val_ff <= -8'sd128;
         best_cls_ff <= '0;
         rec_ff      <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         best_val_ff <= best_val_in;
         best_cls_ff <= best_cls_in;
         rec_ff      <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (pos_cur < yrd_pkg::HEAD_LAST) begin
            coords_ff[pos_cur[1:0]] <= req.element;
         end else if (pos_cur == yrd_pkg::HEAD_LAST) begin
            score_ff <= req.element;
         end
      end
   end

endmodule

// ----- hdl/yrd_job_fifo.sv -----
// ----------------------------------------------------------------------------
// yrd_job_fifo
// Short record queue between the element front end and the box back end.
// ----------------------------------------------------------------------------
module yrd_job_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  yrd_pkg::job_type          push_job,
   input  logic                      pop,
   output yrd_pkg::job_type          head,
   output yrd_pkg::queue_status_type status
);

   yrd_pkg::job_type                 mem_ff [yrd_pkg::QUEUE_DEPTH];
   logic [yrd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [yrd_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [yrd_pkg::QUEUE_PTR_W:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == (yrd_pkg::QUEUE_PTR_W+1)'(yrd_pkg::QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("record pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("record popped from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a push");
`endif

endmodule

// ----- hdl/yrd_back.sv -----
// ----------------------------------------------------------------------------
// yrd_back
// Dequantizes a queued record through a shared two-multiplier pipeline, one
// operand per cycle, and holds the resulting box in the output register.
// ----------------------------------------------------------------------------
module yrd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  yrd_pkg::cfg_type          cfg,
   input  yrd_pkg::job_type          job,
   input  yrd_pkg::queue_status_type q_status,
   output logic                      pop,
   yrd_rsp_if.source                 rsp
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   localparam logic [2:0] OP_SCORE = 3'd0;
   localparam logic [2:0] OP_X     = 3'd1;
   localparam logic [2:0] OP_Y     = 3'd2;
   localparam logic [2:0] OP_W     = 3'd3;
   localparam logic [2:0] OP_H     = 3'd4;

   state_type                         state_ff, state_in;
   logic [2:0]                        issue_ff, issue_in;

   // stage 1: (q - zp) * scale
   logic                              vld1_ff;
   logic [2:0]                        op1_ff;
   logic signed [yrd_pkg::DQ_W-1:0]   v1_ff;
   // stage 2: reciprocal or inv_size product
   logic                              vld2_ff;
   logic [2:0]                        op2_ff;
   logic [31:0]                       u2_ff;
   logic                              pos2_ff;
   logic [63:0]                       prod2_ff;

   logic                              emit_ff;
   logic [yrd_pkg::REC_W-1:0]         rec_ff;
   logic [yrd_pkg::CLS_W-1:0]         cls_ff;
   logic [yrd_pkg::SCORE_W-1:0]       score_ff;
   logic [yrd_pkg::COORD_W-1:0]       box_x_ff, box_y_ff, box_w_ff, box_h_ff;

   logic                              issue;
   logic signed [yrd_pkg::ELEM_W-1:0] operand;
   logic signed [yrd_pkg::ELEM_W:0]   diff;
   logic signed [yrd_pkg::DQ_W:0]     dq_full;
   logic [31:0]                       mul_b;
   logic [31:0]                       score_val;
   logic                              score_pass;
   logic [yrd_pkg::SCORE_W-1:0]       score_sat;
   logic [31:0]                       coord_val;
   logic [yrd_pkg::COORD_W-1:0]       coord_clip;
   logic                              last_done;

   assign issue     = state_ff == ST_RUN;
   assign last_done = vld2_ff && op2_ff == OP_H;

   always_comb begin
      case (issue_ff)
         OP_SCORE: operand = job.score;
         OP_X:     operand = job.coords[0];
         OP_Y:     operand = job.coords[1];
         OP_W:     operand = job.coords[2];
         OP_H:     operand = job.coords[3];
         default:  operand = job.score;
      endcase
      diff    = {operand[yrd_pkg::ELEM_W-1], operand}
              - {cfg.quant_offset[yrd_pkg::ELEM_W-1], cfg.quant_offset};
      dq_full = diff * $signed({1'b0, cfg.scale_q16});

      mul_b = (op1_ff == OP_SCORE) ? yrd_pkg::RECIP_100 : {20'd0, cfg.inv_size};

      score_val  = cfg.pixel_mode ? {6'd0, prod2_ff[63:yrd_pkg::RECIP_SHIFT]} : u2_ff;
      score_pass = pos2_ff && (score_val > {16'd0, cfg.score_threshold});
      score_sat  = (score_val[31:16] != '0) ? '1 : score_val[15:0];

      coord_val = cfg.pixel_mode ? {4'd0, prod2_ff[43:yrd_pkg::Q_FRAC]} : u2_ff;
      if (!pos2_ff) begin
         coord_clip = '0;
      end else if (coord_val > {15'd0, yrd_pkg::COORD_ONE}) begin
         coord_clip = yrd_pkg::COORD_ONE;
      end else begin
         coord_clip = coord_val[yrd_pkg::COORD_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            issue_in = OP_SCORE;
            if (!q_status.empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            issue_in = issue_ff + 3'd1;
            if (issue_ff == OP_H) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (last_done) begin
               pop      = 1'b1;
               state_in = emit_ff ? ST_SEND : ST_IDLE;
            end
         end
         ST_SEND: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= OP_SCORE;
         vld1_ff  <= 1'b0;
         vld2_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         vld1_ff  <= issue;
         vld2_ff  <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= issue_ff;
      v1_ff    <= dq_full[yrd_pkg::DQ_W-1:0];
      op2_ff   <= op1_ff;
      u2_ff    <= v1_ff[31:0];
      pos2_ff  <= !v1_ff[yrd_pkg::DQ_W-1] && (v1_ff != '0);
      prod2_ff <= v1_ff[31:0] * mul_b;
      if (issue && issue_ff == OP_SCORE) begin
         rec_ff <= job.record_index;
         cls_ff <= job.class_index;
      end
      if (vld2_ff) begin
         case (op2_ff)
            OP_SCORE: begin
               emit_ff  <= score_pass;
               score_ff <= score_sat;
            end
            OP_X:    box_x_ff <= coord_clip;
            OP_Y:    box_y_ff <= coord_clip;
            OP_W:    box_w_ff <= coord_clip;
            OP_H:    box_h_ff <= coord_clip;
            default: emit_ff  <= emit_ff;
         endcase
      end
   end

   assign rsp.valid        = state_ff == ST_SEND;
   assign rsp.record_index = rec_ff;
   assign rsp.class_index  = cls_ff;
   assign rsp.score        = score_ff;
   assign rsp.box_x        = box_x_ff;
   assign rsp.box_y        = box_y_ff;
   assign rsp.box_w        = box_w_ff;
   assign rsp.box_h        = box_h_ff;

endmodule

// ----- hdl/yolo_record_decoder.sv -----
// Throughput: the front end takes one element per cycle while the record queue
// has room; the back end works on one record at a time on its shared multiply
// pipeline and takes no new record before its box for the last one has left.
// Reset (synchronous, active high) empties the queue, restarts the record and
// record counters and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// yolo_record_decoder
// Streaming int8 detector output decoder: argmax, dequantization and box gating.
// ----------------------------------------------------------------------------
module yolo_record_decoder #(
   parameter int unsigned MAX_CLASSES = 80,
   parameter int unsigned MAX_RECORDS = 32768
) (
   input  logic                              clock,
   input  logic                              reset,
   yrd_req_if.sink                           req_chan,
   yrd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [yrd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [yrd_pkg::CSR_W-1:0]         csr_wdata
);

   yrd_pkg::cfg_type          cfg_ff, cfg_in;
   yrd_pkg::job_type          push_job;
   yrd_pkg::job_type          head_job;
   yrd_pkg::queue_status_type q_status;
   logic                      push;
   logic                      pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            yrd_pkg::CSR_QUANT_OFFSET: cfg_in.quant_offset    = csr_wdata[7:0];
            yrd_pkg::CSR_SCALE:        cfg_in.scale_q16       = csr_wdata[23:0];
            yrd_pkg::CSR_PIXEL_MODE:   cfg_in.pixel_mode      = csr_wdata[0];
            yrd_pkg::CSR_THRESHOLD:    cfg_in.score_threshold = csr_wdata[15:0];
            yrd_pkg::CSR_CLASS_COUNT:  cfg_in.class_count     = csr_wdata[6:0];
            yrd_pkg::CSR_INV_SIZE:     cfg_in.inv_size        = csr_wdata[11:0];
            yrd_pkg::CSR_RECORD_COUNT: cfg_in.record_count    = csr_wdata[14:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quant_offset    <= '0;
         cfg_ff.scale_q16       <= 24'd65536;
         cfg_ff.pixel_mode      <= 1'b0;
         cfg_ff.score_threshold <= 16'd16384;
         cfg_ff.class_count     <= 7'd80;
         cfg_ff.inv_size        <= 12'd205;
         cfg_ff.record_count    <= 15'd6300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   yrd_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .MAX_RECORDS (MAX_RECORDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_chan),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   yrd_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head_job),
      .status   (q_status)
   );

   yrd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job      (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

// ----- test/tb_yolo_record_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yolo_record_decoder
// Streams int8 detector records into the decoder under a range of register
// settings and handshake pressure. A local bit-accurate decoder predicts every
// box, and each box beat is compared field by field against the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module tb_yolo_record_decoder;

   localparam int CLASS_LIMIT     = 80;
   localparam int RECORD_LIMIT    = 32768;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int ITEMS_PER_PHASE = 145;
   localparam int RANDOM_PHASES   = 13;
   localparam int KEEP_ALL        = 1000;

   typedef struct packed {
      logic [yrd_pkg::REC_W-1:0]   record_index;
      logic [yrd_pkg::CLS_W-1:0]   class_index;
      logic [yrd_pkg::SCORE_W-1:0] score;
      logic [yrd_pkg::COORD_W-1:0] box_x;
      logic [yrd_pkg::COORD_W-1:0] box_y;
      logic [yrd_pkg::COORD_W-1:0] box_w;
      logic [yrd_pkg::COORD_W-1:0] box_h;
   } box_type;

   logic clock = 1'b0;
   logic reset;
   logic                          csr_we;
   logic [yrd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [yrd_pkg::CSR_W-1:0]     csr_wdata;

   yrd_req_if req_if ();
   yrd_rsp_if rsp_if ();

   yolo_record_decoder #(
      .MAX_CLASSES (CLASS_LIMIT),
      .MAX_RECORDS (RECORD_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // decoder state as the testbench tracks it
   yrd_pkg::cfg_type cfg = '{quant_offset: 8'sd0, scale_q16: 24'd65536, pixel_mode: 1'b0,
                             score_threshold: 16'd16384, class_count: 7'd80,
                             inv_size: 12'd205, record_count: 15'd6300};
   int unsigned                       pos = 0;
   logic signed [yrd_pkg::ELEM_W-1:0] best_val = -8'sd128;
   logic [yrd_pkg::CLS_W-1:0]         best_cls = '0;
   logic signed [yrd_pkg::ELEM_W-1:0] cap_coord [4] = '{default: '0};
   logic signed [yrd_pkg::ELEM_W-1:0] cap_score = '0;
   int unsigned                       rec_cnt = 0;

   box_type box_queue [$];

   int error_count        = 0;
   int element_count      = 0;
   int records_decoded    = 0;
   int boxes_expected     = 0;
   int boxes_checked      = 0;
   int settings_count     = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;

   function automatic int unsigned active_classes();
      int unsigned n;
      n = cfg.class_count;
      if (n < 1) n = 1;
      if (n > CLASS_LIMIT) n = CLASS_LIMIT;
      return n;
   endfunction

   function automatic longint dequantize(input logic signed [yrd_pkg::ELEM_W-1:0] q);
      return longint'(int'(q) - int'($signed(cfg.quant_offset))) * longint'(cfg.scale_q16);
   endfunction

   function automatic logic [yrd_pkg::COORD_W-1:0] coord_value(
         input logic signed [yrd_pkg::ELEM_W-1:0] q);
      longint v;
      v = dequantize(q);
      if (v <= 0) return '0;
      if (cfg.pixel_mode) v = (v * longint'(cfg.inv_size)) >> yrd_pkg::Q_FRAC;
      return (v > 65536) ? yrd_pkg::COORD_ONE : yrd_pkg::COORD_W'(v);
   endfunction

   function automatic void restart_scan();
      pos      = 0;
      best_val = -8'sd128;
      best_cls = '0;
   endfunction

   // advance the tracked state by one element; returns 1 when a box is due
   function automatic bit decode_element(input logic signed [yrd_pkg::ELEM_W-1:0] q,
                                         input logic first, output box_type b);
      int unsigned records;
      int unsigned last;
      longint      v;
      longint      s;
      bit          hit;
      hit = 1'b0;
      b = '0;
      records = cfg.record_count;
      if (records < 1) records = 1;
      if (records > RECORD_LIMIT) records = RECORD_LIMIT;
      last = 4 + active_classes();
      if (first) begin
         restart_scan();
         rec_cnt = 0;
      end
      if (pos < 4) begin
         cap_coord[pos] = q;
      end else if (pos == 4) begin
         cap_score = q;
      end else if (q > best_val) begin
         best_val = q;
         best_cls = yrd_pkg::CLS_W'(pos - 5);
      end
      if (pos >= last) begin
         v = dequantize(cap_score);
         if (v > 0) begin
            s = cfg.pixel_mode ? v / 100 : v;
            // gate on the unsaturated score
            if (s > longint'(cfg.score_threshold)) begin
               b.record_index = yrd_pkg::REC_W'(rec_cnt);
               b.class_index  = best_cls;
               b.score        = (s > 65535) ? 16'hFFFF : yrd_pkg::SCORE_W'(s);
               b.box_x        = coord_value(cap_coord[0]);
               b.box_y        = coord_value(cap_coord[1]);
               b.box_w        = coord_value(cap_coord[2]);
               b.box_h        = coord_value(cap_coord[3]);
               hit = 1'b1;
            end
         end
         restart_scan();
         rec_cnt = (rec_cnt + 1 >= records) ? 0 : rec_cnt + 1;
         records_decoded++;
      end else begin
         pos = pos + 1;
      end
      if (hit) boxes_expected++;
      return hit;
   endfunction

   function automatic yrd_pkg::cfg_type make_settings(input int zp, input int unsigned scale,
                                                      input bit pix, input int unsigned thr,
                                                      input int unsigned cls,
                                                      input int unsigned inv,
                                                      input int unsigned rc);
      yrd_pkg::cfg_type c;
      c.quant_offset    = yrd_pkg::ELEM_W'(zp);
      c.scale_q16       = yrd_pkg::SCALE_W'(scale);
      c.pixel_mode      = pix;
      c.score_threshold = yrd_pkg::SCORE_W'(thr);
      c.class_count     = yrd_pkg::CLS_W'(cls);
      c.inv_size        = yrd_pkg::INV_W'(inv);
      c.record_count    = yrd_pkg::REC_W'(rc);
      return c;
   endfunction

   function automatic yrd_pkg::cfg_type random_settings();
      yrd_pkg::cfg_type c;
      c.quant_offset = yrd_pkg::ELEM_W'($urandom);
      case ($urandom_range(2))
         0: c.scale_q16 = yrd_pkg::SCALE_W'($urandom_range(1, 131072));
         1: c.scale_q16 = yrd_pkg::SCALE_W'($urandom_range(6554, 65536));
         default: c.scale_q16 = yrd_pkg::SCALE_W'($urandom);
      endcase
      c.pixel_mode      = 1'($urandom);
      c.score_threshold = ($urandom_range(3) == 0) ? yrd_pkg::SCORE_W'($urandom)
                                                   : yrd_pkg::SCORE_W'($urandom_range(0, 4095));
      c.class_count     = ($urandom_range(9) == 0) ? '0 : yrd_pkg::CLS_W'($urandom_range(1, 8));
      c.inv_size        = yrd_pkg::INV_W'($urandom);
      c.record_count    = yrd_pkg::REC_W'($urandom_range(0, 12));
      return c;
   endfunction

   task automatic write_settings(input yrd_pkg::cfg_type c);
      logic [yrd_pkg::CSR_IDX_W-1:0] idx [7];
      logic [yrd_pkg::CSR_W-1:0]     val [7];
      idx = '{yrd_pkg::CSR_QUANT_OFFSET, yrd_pkg::CSR_SCALE, yrd_pkg::CSR_PIXEL_MODE,
              yrd_pkg::CSR_THRESHOLD, yrd_pkg::CSR_CLASS_COUNT, yrd_pkg::CSR_INV_SIZE,
              yrd_pkg::CSR_RECORD_COUNT};
      val = '{yrd_pkg::CSR_W'($unsigned(c.quant_offset)), yrd_pkg::CSR_W'(c.scale_q16),
              yrd_pkg::CSR_W'(c.pixel_mode), yrd_pkg::CSR_W'(c.score_threshold),
              yrd_pkg::CSR_W'(c.class_count), yrd_pkg::CSR_W'(c.inv_size),
              yrd_pkg::CSR_W'(c.record_count)};
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg = c;
      settings_count++;
   endtask

   // drop valid, drain all pending boxes, then let the back end settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (box_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_element(input logic signed [yrd_pkg::ELEM_W-1:0] value,
                               input logic first);
      box_type b;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.element     <= value;
      req_if.frame_start <= first;
      do @(posedge clock); while (!req_if.ready);
      if (decode_element(value, first, b)) box_queue.push_back(b);
      element_count++;
   endtask

   task automatic send_bytes(input byte seq [$], input bit first);
      foreach (seq[i]) send_element(seq[i], first && i == 0);
   endtask

   // well-formed record with random content, cut short after keep elements
   task automatic send_record(input bit first, input int unsigned keep);
      int unsigned n;
      int unsigned i;
      int unsigned style;
      logic signed [yrd_pkg::ELEM_W-1:0] e;
      n = 5 + active_classes();
      style = $urandom_range(9);
      for (i = 0; i < n && i < keep; i++) begin
         if (i < 5 || style > 2) begin
            e = yrd_pkg::ELEM_W'($urandom);
         end else if (style == 0) begin
            e = -8'sd128;
         end else begin
            // few distinct values so ties show up
            case ($urandom_range(2))
               0: e = -8'sd128;
               1: e = 8'sd0;
               default: e = 8'sd127;
            endcase
         end
         send_element(e, first && i == 0);
      end
   endtask

   task automatic test_field_extremes();
      wait_idle();
      write_settings(make_settings(0, 65536, 0, 16384, 1, 205, 2));
      // saturated score, clipped coordinates and class byte at minimum, then no box
      send_bytes('{-128, 127, 0, 1, 127, -128}, 1'b1);
      send_bytes('{1, 2, 3, -1, -128, 127}, 1'b0);
   endtask

   task automatic test_frame_restart_threshold();
      wait_idle();
      // class count 0, record count 0, pixel mode with zero reciprocal
      write_settings(make_settings(-1, 1638400, 1, 16384, 0, 0, 0));
      send_bytes('{9, 9}, 1'b0);
      // score equal to the threshold: no box
      send_bytes('{50, 60, 70, 80, 0, 3}, 1'b1);
      send_bytes('{50, 60, 70, 80, 1, -7}, 1'b0);
   endtask

   task automatic test_class_lowered_midrecord();
      wait_idle();
      write_settings(make_settings(0, 65536, 0, 0, 3, 2048, 32767));
      send_bytes('{10, 20, 30, 40, 5, 8}, 1'b1);
      wait_idle();
      // position is already past the new last element, next byte ends the record
      write_settings(make_settings(0, 65536, 0, 0, 1, 2048, 32767));
      send_bytes('{9}, 1'b0);
   endtask

   task automatic test_random_stream();
      int unsigned      phase;
      int               target;
      int unsigned      r;
      bit               force_fs;
      yrd_pkg::cfg_type fixed [5];
      fixed = '{make_settings(0, 65536, 0, 16384, 3, 205, 7),
                make_settings(-128, 24'hFFFFFF, 1, 65535, 1, 4095, 1),
                make_settings(127, 0, 0, 0, 2, 0, 0),
                make_settings(-20, 6554, 1, 100, 80, 2048, 32767),
                make_settings(3, 65536, 0, 30000, 127, 1, 5)};
      phase = 0;
      while (phase < RANDOM_PHASES) begin
         wait_idle();
         write_settings((phase < 5) ? fixed[phase] : random_settings());
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         target = element_count + ITEMS_PER_PHASE;
         force_fs = 1'b1;
         while (element_count < target) begin
            r = $urandom_range(99);
            if (r < 85) begin
               send_record(force_fs || rec_cnt == 0 || $urandom_range(15) == 0, KEEP_ALL);
               force_fs = 1'b0;
            end else if (r < 95) begin
               send_record(1'b1, $urandom_range(1, 4 + active_classes()));
               force_fs = 1'b1;
            end else begin
               send_element(yrd_pkg::ELEM_W'($urandom), 1'($urandom));
               force_fs = 1'b1;
            end
         end
         phase++;
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin : box_checker
      box_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (box_queue.size() == 0) begin
            $error("box beat with nothing pending: record_index %0d", rsp_if.record_index);
            error_count++;
         end else begin
            want = box_queue.pop_front();
            check_field("record_index", want.record_index, rsp_if.record_index);
            check_field("class_index", want.class_index, rsp_if.class_index);
            check_field("score", want.score, rsp_if.score);
            check_field("box_x", want.box_x, rsp_if.box_x);
            check_field("box_y", want.box_y, rsp_if.box_y);
            check_field("box_w", want.box_w, rsp_if.box_w);
            check_field("box_h", want.box_h, rsp_if.box_h);
            boxes_checked++;
         end
      end
   end

   // count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d boxes pending",
                  quiet_cycles, box_queue.size());
         $display("yolo_record_decoder test failed");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.element     = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_frame_restart_threshold();
      test_class_lowered_midrecord();
      test_random_stream();
      wait_idle();
      $display("covered %0d elements, %0d records under %0d register settings",
               element_count, records_decoded, settings_count);
      $display("checked %0d boxes, %0d errors", boxes_checked, error_count);
      if (error_count == 0) begin
         $display("yolo_record_decoder test passed");
      end else begin
         $display("yolo_record_decoder test failed");
      end
      $finish;
   end

endmodule
